// File: rtl/core/nflp_pkg.sv
package nflp_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HZ_W        = 32;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Status codes carried in the output tuser
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BELOW_MIN = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HZ = 1'b1;

  // Full table marker
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  // Access request from the controller to the table memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [HZ_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/core/nflp_table_ram.sv
module nflp_table_ram
  import nflp_pkg::*;
(
  input  logic            clk_i,
  input  ram_req_t        req_i,
  output logic [HZ_W-1:0] rdata_o
);

  logic [HZ_W-1:0] mem_q [TABLE_DEPTH];
  logic [HZ_W-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/nflp_ctrl.sv
module nflp_ctrl
  import nflp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Incoming transaction
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_cmd_i,
  input  logic [HZ_W-1:0]  in_value_i,
  // Configuration
  input  logic [HZ_W-1:0]  min_hz_i,
  input  logic [HZ_W-1:0]  max_hz_i,
  // Table memory
  output ram_req_t         ram_req_o,
  input  logic [HZ_W-1:0]  ram_rdata_i,
  // Outgoing transaction
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HZ_W-1:0]  out_hz_o,
  output logic [IDX_W-1:0] out_idx_o,
  output logic [CNT_W-1:0] out_cnt_o,
  output logic [1:0]       out_status_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [HZ_W-1:0]  target_q, target_d;
  logic [HZ_W-1:0]  prev_q, prev_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [HZ_W-1:0]  res_hz_q, res_hz_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic [1:0]       res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  logic [HZ_W-1:0]  out_hz_q, out_hz_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [1:0]       out_st_q, out_st_d;

  logic [HZ_W:0]    mid;
  logic             cap_hit;
  logic [IDX_W-1:0] idx_nxt;

  // Midpoint of the candidate and the entry just read, and the cap test on that entry.
  assign mid     = ({1'b0, prev_q} + {1'b0, ram_rdata_i}) >> 1;
  assign cap_hit = (max_hz_i != '0) && (ram_rdata_i >= max_hz_i);
  assign idx_nxt = idx_q + 1'b1;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: accept, walk the table one entry per cycle, hand off the result.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    target_d    = target_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    last_d      = last_q;
    res_hz_d    = res_hz_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_hz_d    = out_hz_q;
    out_idx_d   = out_idx_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    ram_req_o   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          target_d  = in_value_i;
          idx_d     = '0;
          res_hz_d  = '0;
          res_idx_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_FIN;
          unique case (in_cmd_i)
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_APPEND: begin
              if (in_value_i < min_hz_i) begin
                res_st_d = ST_BELOW_MIN;
              end else if (count_q == CNT_FULL) begin
                res_st_d = ST_FULL;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = count_q[IDX_W-1:0];
                ram_req_o.wdata = in_value_i;
                count_d         = count_q + 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = '0;
                last_d          = IDX_W'(count_q - 1'b1);
                state_d         = S_FIRST;
              end
            end
            default: begin
              // Unused command: no state change, plain result.
            end
          endcase
        end
      end

      S_FIRST: begin
        // Entry 0 is the first candidate.
        prev_d = ram_rdata_i;
        if ((last_q == '0) || cap_hit) begin
          res_hz_d  = ram_rdata_i;
          res_idx_d = idx_q;
          state_d   = S_FIN;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_nxt;
          state_d         = S_SCAN;
        end
      end

      S_SCAN: begin
        // The read data is the entry after the current candidate.
        if ({1'b0, target_q} <= mid) begin
          res_hz_d  = prev_q;
          res_idx_d = idx_q;
          state_d   = S_FIN;
        end else begin
          prev_d = ram_rdata_i;
          idx_d  = idx_nxt;
          if ((idx_nxt == last_q) || cap_hit) begin
            res_hz_d  = ram_rdata_i;
            res_idx_d = idx_nxt;
            state_d   = S_FIN;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = idx_nxt + 1'b1;
          end
        end
      end

      S_FIN: begin
        // Load the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_hz_d    = res_hz_q;
          out_idx_d   = res_idx_q;
          out_cnt_d   = count_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    prev_q    <= prev_d;
    idx_q     <= idx_d;
    last_q    <= last_d;
    res_hz_q  <= res_hz_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    out_hz_q  <= out_hz_d;
    out_idx_q <= out_idx_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_hz_o     = out_hz_q;
  assign out_idx_o    = out_idx_q;
  assign out_cnt_o    = out_cnt_q;
  assign out_status_o = out_st_q;

endmodule

// File: rtl/core/nearest_frequency_level_picker.sv
// Channel   Direction  tdata (low bit first)                       tuser
// s_axis    in         value_hz[31:0], 0 pad to 32                  cmd[1:0]
// m_axis    out        result_hz[31:0], result_index[4:0],          status[1:0]
//                      entry_count[5:0], 0 pad to 48
// cfg       in         cfg_idx_i 0 = min_assignable_hz, 1 = max_hz, no read-back
//
// Clear, append and unused commands pass from acceptance through S_FIN to the output register.
// A lookup reads one table entry per cycle from the single read port of the table
// memory and walks at most 32 entries.
// Reset clears the entry count, the sequencer and the output valid; the table needs no clearing.
// A stalled output holds the result; one more transaction is taken and parked meanwhile.
module nearest_frequency_level_picker
  import nflp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // value_hz[31:0]
  input  logic [1:0]           s_axis_tuser,   // cmd[1:0]
  // Output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // result_hz, result_index, entry_count
  output logic [1:0]           m_axis_tuser,   // status[1:0]
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HZ_W-1:0]      cfg_data_i
);

  logic [HZ_W-1:0]  min_hz_q;
  logic [HZ_W-1:0]  max_hz_q;
  ram_req_t         ram_req;
  logic [HZ_W-1:0]  ram_rdata;
  logic [HZ_W-1:0]  out_hz;
  logic [IDX_W-1:0] out_idx;
  logic [CNT_W-1:0] out_cnt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hz_q <= '0;
      max_hz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_HZ: min_hz_q <= cfg_data_i;
        CFG_MAX_HZ: max_hz_q <= cfg_data_i;
      endcase
    end
  end

  nflp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .min_hz_i     (min_hz_q),
    .max_hz_i     (max_hz_q),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_hz_o     (out_hz),
    .out_idx_o    (out_idx),
    .out_cnt_o    (out_cnt),
    .out_status_o (m_axis_tuser)
  );

  nflp_table_ram u_table (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {5'b0, out_cnt, out_idx, out_hz};

endmodule

// File: rtl/core/nflp_checker.sv
module nflp_checker
  import nflp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [31:0]          s_axis_tdata,
  input logic [1:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [47:0]          m_axis_tdata,
  input logic [1:0]           m_axis_tuser,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [HZ_W-1:0]      cfg_data_i
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  // Only one transaction is taken at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

  // The entry count never passes the table depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[42:37] <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A failed command returns no level.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[36:0] == '0))
    else $error("non-zero level with error status");

  // An empty status comes only with an empty table.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[42:37] == '0))
    else $error("empty status with entries present");

endmodule

bind nearest_frequency_level_picker nflp_checker u_nflp_checker (.*);
